@@ rtl/core/srrm_pkg.sv @@
package srrm_pkg;

   localparam int LEN_W       = 11;
   localparam int POS_W       = 10;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 56;

   localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh4000_0000;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAP,
      ST_FINISH
   } state_type;

   // shift strobe and the value entering the tail of the ring
   typedef struct packed {
      logic                     shift;
      logic signed [DATA_W-1:0] tail;
   } ring_ctl_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } result_type;

endpackage

@@ rtl/core/sequence_rotate_range_min_core.sv @@
// Channel | Dir | Beat fields (lowest bit up)
// req     | in  | tuser: operation[1:0]; tdata: first_pos, last_pos, new_value, pad
// rsp     | out | tdata: range_min[31:0]
// csr     | in  | data: seq_length[10:0], always ready
//
// Write, rotate and query beats each go through an accept state, one full lap of the cell
// ring (one cell a cycle) and a finish state.
// Operation code 3 is taken and dropped while idle, with no lap.
// A query result sits in the output register from the cycle after the finish cycle.
// Reset clears the control state and the length; cell contents stay undefined.
// A finished query holds in its finish cycle while the output register is full and not being taken.
module sequence_rotate_range_min_core
   import srrm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // first_pos[9:0], last_pos[19:10], new_value[51:20], zero pad [55:52]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // range_min[31:0]
   output logic [DATA_W-1:0]      rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LEN_W-1:0]       csr_data
);

   logic [LEN_W-1:0]         len_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;

   ring_ctl_type             ring;
   result_type               result;
   logic signed [DATA_W-1:0] head, look;
   logic                     rsp_busy;

   // length register, always ready; a lap in flight already holds its decoded bounds
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_valid) begin
         len_ff <= csr_data;
      end
   end

   // hold a result until the sink takes it
   assign rsp_busy = rsp_valid_ff && !rsp_tready;

   srrm_seq #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_first (req_tdata[9:0]),
      .req_last  (req_tdata[19:10]),
      .req_value (req_tdata[51:20]),
      .seq_len   (len_ff),
      .rsp_busy  (rsp_busy),
      .ring      (ring),
      .head      (head),
      .look      (look),
      .result    (result)
   );

   // the ring: cell 0 is the head, the tail cell takes back what the sequencer returns
   srrm_chain #(
      .DEPTH (MAX_ELEMENTS)
   ) u_chain (
      .clock (clock),
      .ring  (ring),
      .head  (head),
      .look  (look)
   );

   // output register: load a new result, drop the old one once it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_data_ff <= result.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/srrm_cell.sv @@
module srrm_cell
   import srrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     shift,
   input  logic signed [DATA_W-1:0] d,
   output logic signed [DATA_W-1:0] q
);

   logic signed [DATA_W-1:0] value_ff;

   // take the neighbor's value on every shift, hold otherwise
   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= d;
      end
   end

   assign q = value_ff;

endmodule

@@ rtl/core/srrm_chain.sv @@
module srrm_chain
   import srrm_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  ring_ctl_type             ring,
   output logic signed [DATA_W-1:0] head,
   output logic signed [DATA_W-1:0] look
);

   logic signed [DATA_W-1:0] q [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == DEPTH - 1) begin : g_tail
            srrm_cell u_cell (
               .clock (clock),
               .shift (ring.shift),
               .d     (ring.tail),
               .q     (q[i])
            );
         end else begin : g_body
            srrm_cell u_cell (
               .clock (clock),
               .shift (ring.shift),
               .d     (q[i+1]),
               .q     (q[i])
            );
         end
      end
   endgenerate

   assign head = q[0];
   assign look = q[1];

endmodule

@@ rtl/core/srrm_seq.sv @@
module srrm_seq
   import srrm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic [POS_W-1:0]         req_first,
   input  logic [POS_W-1:0]         req_last,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [LEN_W-1:0]         seq_len,
   input  logic                     rsp_busy,
   output ring_ctl_type             ring,
   input  logic signed [DATA_W-1:0] head,
   input  logic signed [DATA_W-1:0] look,
   output result_type               result
);

   localparam int PW = $clog2(MAX_ELEMENTS);
   localparam int CW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_ELEMENTS);
   localparam logic [PW-1:0] TOP_POS = PW'(MAX_ELEMENTS - 1);

   state_type                state_ff, state_in;
   logic [PW-1:0]            cnt_ff, cnt_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [CW-1:0]            first_ff, first_in;
   logic [CW-1:0]            last_ff, last_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     act_ff, act_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic signed [DATA_W-1:0] min_ff, min_in;

   logic [CW-1:0] len_c, first_c, last_c, clip_c, pos_c;
   logic          act_c;

   // decode the incoming beat against the live length
   always_comb begin
      len_c   = (CW'(seq_len) > MAX_C) ? MAX_C : CW'(seq_len);
      first_c = CW'(req_first);
      last_c  = CW'(req_last);
      clip_c  = (len_c != '0 && last_c >= len_c) ? len_c - 1'b1 : last_c;
      unique case (req_op)
         OP_WRITE:  act_c = first_c < len_c;
         OP_ROTATE: act_c = (first_c < last_c) && (last_c < len_c);
         OP_QUERY:  act_c = (first_c < len_c) && (first_c <= clip_c);
         default:   act_c = 1'b0;
      endcase
   end

   assign pos_c = CW'(cnt_ff);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      value_in  = value_ff;
      act_in    = act_ff;
      hold_in   = hold_ff;
      min_in    = min_ff;
      req_ready = 1'b0;
      ring.shift = 1'b0;
      ring.tail  = head;
      result.valid = 1'b0;
      result.value = min_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               first_in = first_c;
               last_in  = (req_op == OP_QUERY) ? clip_c : last_c;
               value_in = req_value;
               act_in   = act_c;
               min_in   = EMPTY_MIN;
               if (req_op != OP_NONE) begin
                  cnt_in   = TOP_POS;
                  state_in = ST_LAP;
               end
            end
         end
         ST_LAP: begin
            ring.shift = 1'b1;
            if (act_ff) begin
               unique case (op_ff)
                  OP_WRITE: begin
                     if (pos_c == first_ff) begin
                        ring.tail = value_ff;
                     end
                  end
                  OP_ROTATE: begin
                     // drop the last element into hold, pull the rest up by one
                     priority if (pos_c == last_ff) begin
                        hold_in   = head;
                        ring.tail = look;
                     end else if (pos_c > first_ff && pos_c < last_ff) begin
                        ring.tail = look;
                     end else if (pos_c == first_ff) begin
                        ring.tail = hold_ff;
                     end else begin
                        ring.tail = head;
                     end
                  end
                  OP_QUERY: begin
                     priority if (pos_c == last_ff) begin
                        min_in = head;
                     end else if (pos_c >= first_ff && pos_c < last_ff
                                  && head < min_ff) begin
                        min_in = head;
                     end else begin
                        min_in = min_ff;
                     end
                  end
                  default: ;
               endcase
            end
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (op_ff == OP_QUERY) begin
               if (!rsp_busy) begin
                  result.valid = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      value_ff <= value_in;
      act_ff   <= act_in;
      hold_ff  <= hold_in;
      min_ff   <= min_in;
   end

endmodule

@@ rtl/core/srrm_check.sv @@
module srrm_check
   import srrm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [OP_W-1:0]        req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [DATA_W-1:0]      rsp_tdata,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [LEN_W-1:0]       csr_data
);

   // a stalled result beat holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a real operation starts a lap, so the next beat cannot be taken at once
   a_lap_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != OP_NONE |=> !req_tready)
      else $error("request taken during a lap");

   // a new result only comes out of a finish cycle
   a_rsp_after_lap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a finished lap");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind sequence_rotate_range_min_core srrm_check u_check (.*);
